// ===== hw/rtl/quadratic_interp_resampler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic interpolation resampler
// Shared concurrent check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH
`define QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH

// same-cycle implication
`define QIR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("resampler check failed in %m");

// next-cycle implication
`define QIR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("resampler check failed in %m");

`endif

// ===== hw/rtl/qir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qir_pkg
// Types and fixed constants of the quadratic interpolation resampler.
// ----------------------------------------------------------------------------
package qir_pkg;

	localparam int STEP_W      = 21;
	localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
	localparam int SAMPLE_W    = 16;
	localparam int MAX_RESULTS = 48;
	localparam int CNT_W       = 6;
	localparam int JOB_DEPTH   = 4;
	localparam int OUT_DEPTH   = 8;
	localparam int CREDIT_W    = $clog2(OUT_DEPTH + 1);

	// job kinds
	localparam logic [1:0] KIND_COPY   = 2'd0;
	localparam logic [1:0] KIND_INTERP = 2'd1;
	localparam logic [1:0] KIND_MARK   = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] result_sample;
		logic                       run_end;
		logic                       stream_end;
		logic                       empty_res;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       run_end;
		logic       stream_end;
	} job_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quadratic_interp_resampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_interp_resampler
// Fixed-ratio quadratic interpolation resampler, one channel, Q1.15 samples.
// ----------------------------------------------------------------------------
// Input queue side: drive item and push; the item is taken when full is low.
// Result queue side: result holds the oldest result while empty is low; pop
// takes it. cfg_valid/cfg_ready write the step register (Q.FRAC_BITS input
// samples per output); write it only while no stream item is in flight.
// Each input holds the front until all its results (up to 48) are issued:
// the front issues one job per cycle into a 4-entry job queue while it has
// room. The back pipeline turns one job per cycle into a result while it
// holds result queue credit; a result passes from the job queue through
// back stages s1 to s5 into the result queue.
// Sustained back rate is one result per clock while it holds credit, so the
// front sets the input rate. When the receiver stalls, the 8-entry result
// queue fills, the back stops issuing, the job queue fills and the front
// stalls with full held high; nothing is dropped. Reset clears the stream
// state and loads step with one sample per output; it needs no clearing pass.
// The last sample of a stream resets window, index and position; step is kept.
// ----------------------------------------------------------------------------
`include "quadratic_interp_resampler_defines.svh"

module quadratic_interp_resampler #(
	parameter int INDEX_BITS = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire qir_pkg::in_item_t          item,
	output logic                            full,
	output logic                            empty,
	input  wire logic                       pop,
	output qir_pkg::out_item_t              result,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [qir_pkg::STEP_W-1:0] cfg_data
);

	localparam int SW    = qir_pkg::SAMPLE_W;
	localparam int T_W   = FRAC_BITS + 3;
	localparam int JOB_W = $bits(qir_pkg::job_ctl_t) + T_W + 3 * SW;
	localparam int OUT_W = $bits(qir_pkg::out_item_t);

	logic                    job_push;
	logic                    job_full;
	logic                    job_empty;
	logic                    job_pop;
	qir_pkg::job_ctl_t       fj_ctl, bj_ctl;
	logic signed [T_W-1:0]   fj_t, bj_t;
	logic signed [SW-1:0]    fj_y0, fj_y1, fj_y2;
	logic signed [SW-1:0]    bj_y0, bj_y1, bj_y2;
	logic [JOB_W-1:0]        job_wdata;
	logic [JOB_W-1:0]        job_rdata;

	logic                    out_push;
	logic                    out_full;
	logic                    out_release;
	qir_pkg::out_item_t      out_item;
	logic [OUT_W-1:0]        out_rdata;

	qir_front #(
		.INDEX_BITS(INDEX_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cfg_ready(cfg_ready),
		.job_full (job_full),
		.job_push (job_push),
		.job_ctl  (fj_ctl),
		.job_t    (fj_t),
		.job_y0   (fj_y0),
		.job_y1   (fj_y1),
		.job_y2   (fj_y2)
	);

	assign job_wdata = {fj_ctl, fj_t, fj_y0, fj_y1, fj_y2};
	assign {bj_ctl, bj_t, bj_y0, bj_y1, bj_y2} = job_rdata;

	qir_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(qir_pkg::JOB_DEPTH)
	) u_job_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_wdata),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_rdata),
		.empty (job_empty)
	);

	qir_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (job_empty),
		.job_ctl    (bj_ctl),
		.job_t      (bj_t),
		.job_y0     (bj_y0),
		.job_y1     (bj_y1),
		.job_y2     (bj_y2),
		.job_pop    (job_pop),
		.out_release(out_release),
		.out_push   (out_push),
		.out_item   (out_item)
	);

	// a request leaving the result queue frees one credit
	assign out_release = pop && !empty;

	qir_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(qir_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_item),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign result = qir_pkg::out_item_t'(out_rdata);

	`QIR_ASSERT_IMPL(a_out_no_overflow, out_push, !out_full)
	`QIR_ASSERT_IMPL(a_job_no_overflow, job_push, !job_full)
	`QIR_ASSERT_NEXT(a_busy_after_accept, push && !full, full && !cfg_ready)
	`QIR_ASSERT_IMPL(a_marker_is_zero, !empty && result.empty_res, result.result_sample == '0)

endmodule
`default_nettype wire

// ===== hw/rtl/qir_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qir_fifo
// Small register FIFO with full/empty flags. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module qir_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qir_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qir_front
// Accepts input samples, keeps the three-sample window and the output
// position, and issues one job per cycle while the job queue has room.
// ----------------------------------------------------------------------------
module qir_front #(
	parameter int INDEX_BITS = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire qir_pkg::in_item_t              item,
	output logic                                full,
	input  wire logic                           cfg_valid,
	input  wire logic [qir_pkg::STEP_W-1:0]     cfg_data,
	output logic                                cfg_ready,
	input  wire logic                           job_full,
	output logic                                job_push,
	output qir_pkg::job_ctl_t                   job_ctl,
	output logic signed [FRAC_BITS+2:0]         job_t,
	output logic signed [qir_pkg::SAMPLE_W-1:0] job_y0,
	output logic signed [qir_pkg::SAMPLE_W-1:0] job_y1,
	output logic signed [qir_pkg::SAMPLE_W-1:0] job_y2
);

	localparam int POS_W = INDEX_BITS + FRAC_BITS;
	localparam int T_W   = FRAC_BITS + 3;
	localparam int SUM_W = (POS_W > qir_pkg::STEP_W) ? POS_W : qir_pkg::STEP_W;
	localparam int SW    = qir_pkg::SAMPLE_W;
	localparam int CW    = qir_pkg::CNT_W;

	localparam logic [POS_W-1:0] ONE_P     = POS_W'(1) << FRAC_BITS;
	localparam logic [POS_W-1:0] HALF_P    = ONE_P >> 1;
	localparam logic [POS_W-1:0] NEG_ONE_P = ~ONE_P + POS_W'(1);
	localparam logic [qir_pkg::STEP_W-1:0] STEP_MIN = qir_pkg::STEP_W'(1) << (FRAC_BITS - 4);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_GEN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                   state_q;
	logic [qir_pkg::STEP_W-1:0]   step_q;
	logic signed [SW-1:0]         y0_q, y1_q, y2_q;
	logic [INDEX_BITS-1:0]        k_q;
	logic [POS_W-1:0]             pos_q;
	logic                         first_done_q;
	logic                         wfull_q;
	logic                         last_q;
	logic                         any_interp_q;
	logic [CW-1:0]                cnt_q;
	logic                         stg_valid_q;
	qir_pkg::job_ctl_t            stg_ctl_q;
	logic signed [T_W-1:0]        stg_t_q;

	logic [qir_pkg::STEP_W-1:0]   st_eff;
	logic [POS_W-1:0]             st_pos;
	logic [POS_W-1:0]             rel;
	logic                         due;
	logic                         room;
	logic                         can_step;
	logic                         gen_valid;
	logic [1:0]                   gen_kind;
	logic                         gen_end;
	logic                         accept;
	logic                         gen_fire;
	logic                         finish;

	assign full      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = push && !full;

	assign st_eff = (step_q < STEP_MIN) ? STEP_MIN : step_q;
	assign st_pos = POS_W'(SUM_W'(st_eff));
	assign rel    = {k_q, {FRAC_BITS{1'b0}}} - pos_q;
	assign due    = last_q ? ($signed(rel) > $signed(NEG_ONE_P))
	                       : ($signed(rel) > $signed(HALF_P));
	assign room     = (cnt_q < CW'(qir_pkg::MAX_RESULTS));
	assign can_step = !stg_valid_q || !job_full;

	always_comb begin
		gen_valid = 1'b0;
		gen_kind  = qir_pkg::KIND_COPY;
		gen_end   = 1'b0;
		if (!first_done_q) begin
			gen_valid = 1'b1;
		end else if (wfull_q && due && room) begin
			gen_valid = 1'b1;
			gen_kind  = qir_pkg::KIND_INTERP;
		end else begin
			gen_end = 1'b1;
			// no interpolated output landed on this input of the last sample: drop a marker
			if (last_q && !any_interp_q && room) begin
				gen_valid = 1'b1;
				gen_kind  = qir_pkg::KIND_MARK;
			end
		end
	end

	assign gen_fire = (state_q == ST_GEN) && gen_valid && can_step;
	assign finish   = (state_q == ST_FLUSH) && can_step;

	// the staged job goes out once its successor is known or the input is done
	assign job_push = (gen_fire && stg_valid_q)
	               || ((state_q == ST_FLUSH) && stg_valid_q && !job_full);

	always_comb begin
		job_ctl            = stg_ctl_q;
		job_ctl.run_end    = (state_q == ST_FLUSH);
		job_ctl.stream_end = (state_q == ST_FLUSH) && last_q;
	end

	assign job_t  = stg_t_q;
	assign job_y0 = y0_q;
	assign job_y1 = y1_q;
	assign job_y2 = y2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= qir_pkg::STEP_RESET;
			y0_q         <= '0;
			y1_q         <= '0;
			y2_q         <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			first_done_q <= 1'b0;
			wfull_q      <= 1'b0;
			last_q       <= 1'b0;
			any_interp_q <= 1'b0;
			cnt_q        <= '0;
			stg_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						step_q <= cfg_data;
					end
					if (accept) begin
						y0_q         <= y1_q;
						y1_q         <= y2_q;
						y2_q         <= item.sample;
						last_q       <= item.last_sample;
						cnt_q        <= '0;
						any_interp_q <= 1'b0;
						if (k_q >= INDEX_BITS'(2)) begin
							wfull_q <= 1'b1;
						end
						state_q <= ST_GEN;
					end
				end
				ST_GEN: begin
					if (gen_fire) begin
						stg_valid_q <= 1'b1;
						cnt_q       <= cnt_q + CW'(1);
						case (gen_kind)
							qir_pkg::KIND_COPY: begin
								first_done_q <= 1'b1;
								pos_q        <= st_pos;
							end
							qir_pkg::KIND_INTERP: begin
								any_interp_q <= 1'b1;
								pos_q        <= pos_q + st_pos;
							end
							default: begin
							end
						endcase
					end
					if (gen_end && (!gen_valid || can_step)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (finish) begin
						stg_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
						// end of stream: window, index and position back to reset, step kept
						if (last_q) begin
							y0_q         <= '0;
							y1_q         <= '0;
							y2_q         <= '0;
							k_q          <= '0;
							pos_q        <= '0;
							first_done_q <= 1'b0;
							wfull_q      <= 1'b0;
						end else begin
							k_q <= k_q + INDEX_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			stg_ctl_q.kind       <= gen_kind;
			stg_ctl_q.run_end    <= 1'b0;
			stg_ctl_q.stream_end <= 1'b0;
			stg_t_q              <= T_W'(ONE_P - rel);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qir_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qir_back
// Five-stage interpolation pipeline: differences, products, rounding of t^2,
// second product, sum with rounding and saturation. Issues only against
// credit for free result queue entries, so it never stalls.
// ----------------------------------------------------------------------------
module qir_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           job_empty,
	input  wire qir_pkg::job_ctl_t              job_ctl,
	input  wire logic signed [FRAC_BITS+2:0]    job_t,
	input  wire logic signed [qir_pkg::SAMPLE_W-1:0] job_y0,
	input  wire logic signed [qir_pkg::SAMPLE_W-1:0] job_y1,
	input  wire logic signed [qir_pkg::SAMPLE_W-1:0] job_y2,
	output logic                                job_pop,
	input  wire logic                           out_release,
	output logic                                out_push,
	output qir_pkg::out_item_t                  out_item
);

	localparam int SW    = qir_pkg::SAMPLE_W;
	localparam int T_W   = FRAC_BITS + 3;
	localparam int TT_W  = 2 * T_W;
	localparam int T2_W  = TT_W - FRAC_BITS;
	localparam int D1_W  = SW + 1;
	localparam int D2_W  = SW + 2;
	localparam int P1_W  = T_W + D1_W;
	localparam int P2_W  = T2_W + 1 + D2_W;
	localparam int NUM_W = P2_W + 3;
	localparam int CR_W  = qir_pkg::CREDIT_W;

	localparam logic [TT_W-1:0]         HALF_TT = TT_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [NUM_W-1:0] ONE_N   = NUM_W'(1) << FRAC_BITS;
	localparam logic signed [NUM_W-1:0] SAT_HI  = NUM_W'(32767);
	localparam logic signed [NUM_W-1:0] SAT_LO  = NUM_W'(-32768);

	logic [CR_W-1:0] credit_q;
	logic            issue;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	qir_pkg::job_ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [T_W-1:0]    t_s1;
	logic signed [SW-1:0]     y1_s1, y1_s2, y1_s3, y1_s4;
	logic signed [SW-1:0]     y2_s1, y2_s2, y2_s3, y2_s4;
	logic signed [D1_W-1:0]   d1_s1;
	logic signed [D2_W-1:0]   d2_s1, d2_s2, d2_s3;
	logic [TT_W-1:0]          tt_s2;
	logic signed [P1_W-1:0]   td1_s2, td1_s3, td1_s4;
	logic [T2_W-1:0]          t2_s3;
	logic signed [P2_W-1:0]   t2d2_s4;
	qir_pkg::out_item_t       item_s5;

	logic signed [D1_W-1:0]   d1_c;
	logic signed [D2_W-1:0]   d2_c;
	logic signed [NUM_W-1:0]  y1_n, td1_n, t2d2_n, num, yq;
	logic signed [SW-1:0]     ysat;
	qir_pkg::out_item_t       item_c;

	assign issue   = !job_empty && (credit_q != '0);
	assign job_pop = issue;

	assign d1_c = D1_W'(job_y2) - D1_W'(job_y0);
	assign d2_c = D2_W'(job_y2) + D2_W'(job_y0) - (D2_W'(job_y1) <<< 1);

	assign y1_n   = NUM_W'(y1_s4);
	assign td1_n  = NUM_W'(td1_s4);
	assign t2d2_n = NUM_W'(t2d2_s4);
	assign num    = (y1_n <<< (FRAC_BITS + 1)) + td1_n + t2d2_n + ONE_N;
	assign yq     = num >>> (FRAC_BITS + 1);

	always_comb begin
		if (yq > SAT_HI) begin
			ysat = SW'(SAT_HI);
		end else if (yq < SAT_LO) begin
			ysat = SW'(SAT_LO);
		end else begin
			ysat = SW'(yq);
		end
	end

	always_comb begin
		item_c.run_end    = ctl_s4.run_end;
		item_c.stream_end = ctl_s4.stream_end;
		case (ctl_s4.kind)
			qir_pkg::KIND_COPY: begin
				item_c.result_sample = y2_s4;
				item_c.empty_res     = 1'b0;
			end
			qir_pkg::KIND_INTERP: begin
				item_c.result_sample = ysat;
				item_c.empty_res     = 1'b0;
			end
			default: begin
				item_c.result_sample = '0;
				item_c.empty_res     = 1'b1;
			end
		endcase
	end

	assign out_push = v_s5;
	assign out_item = item_s5;

	// one credit per free result queue entry not already claimed in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CR_W'(qir_pkg::OUT_DEPTH);
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
		end else begin
			if (issue && !out_release) begin
				credit_q <= credit_q - CR_W'(1);
			end else if (out_release && !issue) begin
				credit_q <= credit_q + CR_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= job_ctl;
		t_s1    <= job_t;
		y1_s1   <= job_y1;
		y2_s1   <= job_y2;
		d1_s1   <= d1_c;
		d2_s1   <= d2_c;

		ctl_s2  <= ctl_s1;
		tt_s2   <= TT_W'(t_s1 * t_s1);
		td1_s2  <= P1_W'(t_s1 * d1_s1);
		y1_s2   <= y1_s1;
		y2_s2   <= y2_s1;
		d2_s2   <= d2_s1;

		ctl_s3  <= ctl_s2;
		t2_s3   <= T2_W'((tt_s2 + HALF_TT) >> FRAC_BITS);
		td1_s3  <= td1_s2;
		y1_s3   <= y1_s2;
		y2_s3   <= y2_s2;
		d2_s3   <= d2_s2;

		ctl_s4  <= ctl_s3;
		t2d2_s4 <= P2_W'($signed({1'b0, t2_s3}) * d2_s3);
		td1_s4  <= td1_s3;
		y1_s4   <= y1_s3;
		y2_s4   <= y2_s3;

		item_s5 <= item_c;
	end

endmodule
`default_nettype wire
